FILE: hdl/lge_pkg.sv
// Shared types, codes and the B3/S23 cell rule for the life generation engine.
package lge_pkg;

    localparam int CFG_W       = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int ROW_FIELD_W = 6;
    localparam int COL_FIELD_W = 6;
    localparam int COUNT_W     = 13;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 16;
    localparam int OP_W        = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

    localparam logic [3:0] BIRTH_COUNT = 4'd3;
    localparam logic [3:0] SURVIVE_MIN = 4'd2;
    localparam logic [3:0] SURVIVE_MAX = 4'd3;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE,
        OP_READ,
        OP_STEP,
        OP_NONE
    } lge_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CELL,
        ST_FIRST,
        ST_FETCH,
        ST_SCAN,
        ST_WRITE
    } lge_state_t;

    // Next value of one cell given its current value and live neighbor count.
    function automatic logic life_rule(input logic alive, input logic [3:0] nbr);
        logic result;
        if (alive) begin
            result = (nbr >= SURVIVE_MIN) && (nbr <= SURVIVE_MAX);
        end else begin
            result = (nbr == BIRTH_COUNT);
        end
        return result;
    endfunction

endpackage

FILE: hdl/lge_row_store.sv
// Row-wide cell memory with per-row valid bits that read as an all-dead row.
module lge_row_store #(
    parameter int ROWS  = 64,
    parameter int COLS  = 64,
    parameter int ROW_W = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             clear,
    input  logic             rd_en,
    input  logic [ROW_W-1:0] rd_addr,
    output logic [COLS-1:0]  rd_row,
    input  logic             wr_en,
    input  logic [ROW_W-1:0] wr_addr,
    input  logic [COLS-1:0]  wr_row
);

    logic [COLS-1:0] mem [ROWS];
    logic [ROWS-1:0] valid_reg;
    logic [COLS-1:0] rd_data_reg;
    logic            rd_valid_reg;

    // Clearing drops every valid bit at once; stale contents then read as dead.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (clear) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_row;
        end
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_row = rd_valid_reg ? rd_data_reg : '0;

endmodule

FILE: hdl/life_generation_engine_unit.sv
// Game of Life engine (B3/S23, dead border) with cell read/write and generation step.
// A cell write or read inside the grid reads its row and gives its result from ST_CELL;
// an access outside the grid, an unused opcode or a step on an empty grid is answered from ST_IDLE.
// A generation does one neighbor count per cycle plus a row write and a row fetch per
// row. Only one item is handled at a time; the next is taken once the sequencer is idle
// and the result slot is free or being taken.
// Reset is synchronous and active low; it sets a 64 by 64 grid (or the maximum) and marks
// every row dead at once, so no clearing pass is needed.
module life_generation_engine_unit
    import lge_pkg::*;
#(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLUMNS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input items.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // row[5:0], column[11:6], cell_value[12], zero
    input  logic [OP_W-1:0]       s_tuser,   // opcode[1:0]
    // Result items.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // read_value[0], changed_cells[13:1], zero
    output logic                  m_tuser,   // out_of_range[0]
    // Configuration writes.
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    // The 7-bit size registers cap the usable grid at 127 by 127 whatever the maximum.
    localparam int ROWS_USED = (MAX_ROWS < 127) ? MAX_ROWS : 127;
    localparam int COLS_USED = (MAX_COLUMNS < 127) ? MAX_COLUMNS : 127;
    localparam int ROW_W     = (ROWS_USED > 1) ? $clog2(ROWS_USED) : 1;
    localparam int COL_W     = (COLS_USED > 1) ? $clog2(COLS_USED) : 1;
    localparam logic [CFG_W-1:0] ROWS_LIM = CFG_W'(ROWS_USED);
    localparam logic [CFG_W-1:0] COLS_LIM = CFG_W'(COLS_USED);
    localparam logic [CFG_W-1:0] ROWS_RST = CFG_W'((MAX_ROWS < 64) ? MAX_ROWS : 64);
    localparam logic [CFG_W-1:0] COLS_RST = CFG_W'((MAX_COLUMNS < 64) ? MAX_COLUMNS : 64);

    // Configuration and sequencer state.
    logic [CFG_W-1:0]   grid_rows_reg, grid_rows_next;
    logic [CFG_W-1:0]   grid_cols_reg, grid_cols_next;
    lge_state_t         state_reg, state_next;
    lge_op_t            op_reg, op_next;
    logic [CFG_W-1:0]   row_reg, row_next;
    logic [CFG_W-1:0]   col_reg, col_next;
    logic               val_reg, val_next;
    logic               nxt_ok_reg, nxt_ok_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    // Three-row window of the old grid and the row being built.
    logic [COLS_USED-1:0] prev_reg, prev_next;
    logic [COLS_USED-1:0] cur_reg, cur_next;
    logic [COLS_USED-1:0] nxt_reg, nxt_next;
    logic [COLS_USED-1:0] new_row_reg, new_row_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic               out_read_reg, out_read_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic               out_oor_reg, out_oor_next;

    // Row memory port signals.
    logic                 clear;
    logic                 rd_en;
    logic [ROW_W-1:0]     rd_addr;
    logic [COLS_USED-1:0] rd_row;
    logic                 wr_en;
    logic [ROW_W-1:0]     wr_addr;
    logic [COLS_USED-1:0] wr_row;

    // Input decode.
    lge_op_t                op_in;
    logic [ROW_FIELD_W-1:0] row_in;
    logic [COL_FIELD_W-1:0] col_in;
    logic                   val_in;
    logic                   inside_in;
    logic                   accept;

    // Shared neighbor counter.
    logic [COL_W-1:0]     ci;
    logic [COLS_USED-1:0] prev_w, prev_e, cur_w, cur_e, nxt_w, nxt_e;
    logic [3:0]           nbr;
    logic                 cur_bit;
    logic                 new_bit;

    logic [CFG_W:0]       row_plus1;
    logic [CFG_W:0]       row_plus2;
    logic [COLS_USED-1:0] cell_row;

    lge_row_store #(
        .ROWS  (ROWS_USED),
        .COLS  (COLS_USED),
        .ROW_W (ROW_W)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (clear),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_row  (rd_row),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_row  (wr_row)
    );

    assign op_in     = lge_op_t'(s_tuser);
    assign row_in    = s_tdata[ROW_FIELD_W-1:0];
    assign col_in    = s_tdata[ROW_FIELD_W+COL_FIELD_W-1:ROW_FIELD_W];
    assign val_in    = s_tdata[ROW_FIELD_W+COL_FIELD_W];
    assign inside_in = ({1'b0, row_in} < grid_rows_reg) && ({1'b0, col_in} < grid_cols_reg);

    // A new item may enter once the sequencer is idle and the result slot is free
    // or being emptied in this cycle.
    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // Writing either size register starts a new, all-dead world.
    assign clear = cfg_wr_en && ((cfg_index == CFG_ROWS) || (cfg_index == CFG_COLS));

    // Shifting a row by one puts the west (or east) neighbor of column c at bit c;
    // zero fill makes the left and right borders dead.
    assign ci      = col_reg[COL_W-1:0];
    assign prev_w  = prev_reg << 1;
    assign prev_e  = prev_reg >> 1;
    assign cur_w   = cur_reg << 1;
    assign cur_e   = cur_reg >> 1;
    assign nxt_w   = nxt_reg << 1;
    assign nxt_e   = nxt_reg >> 1;
    assign nbr     = 4'($countones({prev_w[ci], prev_reg[ci], prev_e[ci],
                                    cur_w[ci], cur_e[ci],
                                    nxt_w[ci], nxt_reg[ci], nxt_e[ci]}));
    assign cur_bit = cur_reg[ci];
    assign new_bit = life_rule(cur_bit, nbr);

    assign row_plus1 = {1'b0, row_reg} + (CFG_W+1)'(1);
    assign row_plus2 = {1'b0, row_reg} + (CFG_W+1)'(2);

    // Sequencer: a cell read fetches one row, a cell write is a read-modify-write of one row;
    // a generation walks the grid row by row, column by column, through the neighbor counter.
    always_comb begin
        grid_rows_next = grid_rows_reg;
        grid_cols_next = grid_cols_reg;
        state_next     = state_reg;
        op_next        = op_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        val_next       = val_reg;
        nxt_ok_next    = nxt_ok_reg;
        count_next     = count_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        nxt_next       = nxt_reg;
        new_row_next   = new_row_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_read_next  = out_read_reg;
        out_count_next = out_count_reg;
        out_oor_next   = out_oor_reg;
        rd_en          = 1'b0;
        rd_addr        = ROW_W'(row_reg);
        wr_en          = 1'b0;
        wr_addr        = ROW_W'(row_reg);
        wr_row         = new_row_reg;
        cell_row       = rd_row;

        if (cfg_wr_en) begin
            if (cfg_index == CFG_ROWS) begin
                grid_rows_next = (cfg_data > ROWS_LIM) ? ROWS_LIM : cfg_data;
            end else if (cfg_index == CFG_COLS) begin
                grid_cols_next = (cfg_data > COLS_LIM) ? COLS_LIM : cfg_data;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next  = op_in;
                    row_next = {1'b0, row_in};
                    col_next = {1'b0, col_in};
                    val_next = val_in;
                    case (op_in) inside
                        OP_WRITE, OP_READ: begin
                            if (inside_in) begin
                                rd_en      = 1'b1;
                                rd_addr    = ROW_W'(row_in);
                                state_next = ST_CELL;
                            end else begin
                                out_valid_next = 1'b1;
                                out_read_next  = 1'b0;
                                out_count_next = '0;
                                out_oor_next   = 1'b1;
                            end
                        end
                        OP_STEP: begin
                            if ((grid_rows_reg != '0) && (grid_cols_reg != '0)) begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                row_next   = '0;
                                count_next = '0;
                                state_next = ST_FIRST;
                            end else begin
                                out_valid_next = 1'b1;
                                out_read_next  = 1'b0;
                                out_count_next = '0;
                                out_oor_next   = 1'b0;
                            end
                        end
                        default: begin
                            out_valid_next = 1'b1;
                            out_read_next  = 1'b0;
                            out_count_next = '0;
                            out_oor_next   = 1'b0;
                        end
                    endcase
                end
            end
            ST_CELL: begin
                cell_row[ci]   = val_reg;
                out_valid_next = 1'b1;
                out_count_next = '0;
                out_oor_next   = 1'b0;
                out_read_next  = 1'b0;
                if (op_reg == OP_WRITE) begin
                    wr_en  = 1'b1;
                    wr_row = cell_row;
                end else begin
                    out_read_next = rd_row[ci];
                end
                state_next = ST_IDLE;
            end
            ST_FIRST: begin
                // Row 0 is here; the row above it lies outside the grid.
                cur_next    = rd_row;
                prev_next   = '0;
                nxt_ok_next = row_plus1 < {1'b0, grid_rows_reg};
                rd_en       = row_plus1 < {1'b0, grid_rows_reg};
                rd_addr     = ROW_W'(row_plus1);
                state_next  = ST_FETCH;
            end
            ST_FETCH: begin
                nxt_next     = nxt_ok_reg ? rd_row : '0;
                new_row_next = cur_reg;
                col_next     = '0;
                state_next   = ST_SCAN;
            end
            ST_SCAN: begin
                new_row_next[ci] = new_bit;
                if ((new_bit != cur_bit) && (count_reg != '1)) begin
                    count_next = count_reg + COUNT_W'(1);
                end
                col_next = col_reg + CFG_W'(1);
                if ((col_reg + CFG_W'(1)) == grid_cols_reg) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                // The old row stays in the window, so it can be overwritten now.
                wr_en       = 1'b1;
                wr_row      = new_row_reg;
                prev_next   = cur_reg;
                cur_next    = nxt_reg;
                nxt_ok_next = row_plus2 < {1'b0, grid_rows_reg};
                rd_en       = row_plus2 < {1'b0, grid_rows_reg};
                rd_addr     = ROW_W'(row_plus2);
                row_next    = row_plus1[CFG_W-1:0];
                if (row_plus1 == {1'b0, grid_rows_reg}) begin
                    out_valid_next = 1'b1;
                    out_read_next  = 1'b0;
                    out_count_next = count_reg;
                    out_oor_next   = 1'b0;
                    state_next     = ST_IDLE;
                end else begin
                    state_next = ST_FETCH;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            grid_rows_reg <= ROWS_RST;
            grid_cols_reg <= COLS_RST;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            grid_rows_reg <= grid_rows_next;
            grid_cols_reg <= grid_cols_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        row_reg       <= row_next;
        col_reg       <= col_next;
        val_reg       <= val_next;
        nxt_ok_reg    <= nxt_ok_next;
        count_reg     <= count_next;
        prev_reg      <= prev_next;
        cur_reg       <= cur_next;
        nxt_reg       <= nxt_next;
        new_row_reg   <= new_row_next;
        out_read_reg  <= out_read_next;
        out_count_reg <= out_count_next;
        out_oor_reg   <= out_oor_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-COUNT_W-1){1'b0}}, out_count_reg, out_read_reg};
    assign m_tuser  = out_oor_reg;

    // The column walk never leaves the grid.
    a_scan_col_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (col_reg < grid_cols_reg))
        else $error("column walk left the grid");

    // The row walk never leaves the grid.
    a_scan_row_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_SCAN) || (state_reg == ST_WRITE)) |-> (row_reg < grid_rows_reg))
        else $error("row walk left the grid");

    // A generation finishing must find the result slot free.
    a_result_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_WRITE) && (row_plus1 == {1'b0, grid_rows_reg}))
        |-> (!out_valid_reg || m_tready))
        else $error("result overwritten before it was taken");

    // A cell access is answered: in the cycle after ST_CELL a result is valid and the sequencer is idle.
    a_cell_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CELL) |=> (out_valid_reg && (state_reg == ST_IDLE)))
        else $error("cell access gave no result");

endmodule

FILE: dv/life_generation_engine_unit_test.sv
// Self-checking testbench for the Game of Life engine: cell access, generations and sizing.
module life_generation_engine_unit_test;
    import lge_pkg::*;

    // Grid bounds of the engine as instantiated (default parameters).
    localparam int GRID_MAX = 64;
    // Register index that maps to no register; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    // Cycles without any accepted input or result item before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_OFF_CYCLES = 300;

    // One expected or observed result item.
    typedef struct packed {
        logic                read_value;
        logic [COUNT_W-1:0]  changed_cells;
        logic                out_of_range;
    } life_outcome_t;

    // Tracks the grid the engine should hold and the results it still owes.
    class life_grid_tracker;
        bit            cells [GRID_MAX][GRID_MAX];
        int unsigned   rows;
        int unsigned   columns;
        life_outcome_t pending [$];
        int            mismatches;
        int            items_seen;
        int            results_seen;

        function new();
            rows = GRID_MAX;
            columns = GRID_MAX;
            foreach (cells[r, c]) cells[r][c] = 1'b0;
        endfunction

        task report_mismatch(input string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        // Mirrors a register write; any valid index starts a fresh, dead world.
        function void apply_config(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
            int unsigned v;
            v = (value > GRID_MAX) ? GRID_MAX : value;
            if (idx == CFG_ROWS) begin
                rows = v;
            end else if (idx == CFG_COLS) begin
                columns = v;
            end else begin
                return;
            end
            foreach (cells[r, c]) cells[r][c] = 1'b0;
        endfunction

        function bit live_at(input int r, input int c);
            if (r < 0 || c < 0 || r >= rows || c >= columns) return 1'b0;
            return cells[r][c];
        endfunction

        // One B3/S23 generation computed from the old grid; returns cells changed.
        function int unsigned advance_generation();
            bit          upcoming [GRID_MAX][GRID_MAX];
            int unsigned count;
            int unsigned changed;
            bit          now_live;
            bit          next_live;
            upcoming = cells;
            changed = 0;
            for (int r = 0; r < rows; r++) begin
                for (int c = 0; c < columns; c++) begin
                    count = 0;
                    for (int dr = -1; dr <= 1; dr++)
                        for (int dc = -1; dc <= 1; dc++)
                            if (dr != 0 || dc != 0) count += live_at(r + dr, c + dc);
                    now_live = cells[r][c];
                    next_live = now_live;
                    if (!now_live && count == 3) next_live = 1'b1;
                    else if (now_live && (count < 2 || count > 3)) next_live = 1'b0;
                    if (next_live != now_live) begin
                        upcoming[r][c] = next_live;
                        if (changed < 8191) changed++;
                    end
                end
            end
            cells = upcoming;
            return changed;
        endfunction

        // Called for each accepted input item.
        function void note_item(input lge_op_t op, input logic [5:0] row,
                                input logic [5:0] column, input logic value);
            life_outcome_t exp_out;
            bit            in_grid;
            exp_out = '0;
            in_grid = (row < rows) && (column < columns);
            items_seen++;
            case (op)
                OP_WRITE: begin
                    if (in_grid) cells[row][column] = value;
                    else exp_out.out_of_range = 1'b1;
                end
                OP_READ: begin
                    if (in_grid) exp_out.read_value = cells[row][column];
                    else exp_out.out_of_range = 1'b1;
                end
                OP_STEP: begin
                    exp_out.changed_cells = COUNT_W'(advance_generation());
                end
                default: begin
                end
            endcase
            pending.push_back(exp_out);
        endfunction

        // Called for each accepted result item.
        task check_result(input life_outcome_t got);
            life_outcome_t exp_out;
            results_seen++;
            if (pending.size() == 0) begin
                report_mismatch("result item arrived with nothing expected");
                return;
            end
            exp_out = pending.pop_front();
            if (got.read_value !== exp_out.read_value)
                report_mismatch($sformatf("read_value %0b, expected %0b",
                                          got.read_value, exp_out.read_value));
            if (got.changed_cells !== exp_out.changed_cells)
                report_mismatch($sformatf("changed_cells %0d, expected %0d",
                                          got.changed_cells, exp_out.changed_cells));
            if (got.out_of_range !== exp_out.out_of_range)
                report_mismatch($sformatf("out_of_range %0b, expected %0b",
                                          got.out_of_range, exp_out.out_of_range));
        endtask
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [OP_W-1:0]       s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    life_grid_tracker sb;

    // Idle percentages for the current phase, and the long receiver hold-off.
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_off_req = 1'b0;
    logic holding = 1'b0;
    int   quiet_cycles = 0;
    int   settings_used = 1;

    life_generation_engine_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // The receiver stalls at random; during the hold-off it refuses every result,
    // so the engine backs up and must stop taking input items.
    always @(negedge aclk) begin
        m_tready <= !holding && ($urandom_range(99) >= recv_stall_pct);
    end

    // The hold-off is timed here, independently of the sender.
    initial begin : receiver_hold_off
        wait (hold_off_req);
        @(negedge aclk);
        holding <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge aclk);
        holding <= 1'b0;
    end

    // Both handshakes are observed at the rising edge. An input item is noted
    // before a result in the same edge is checked; such a result always belongs
    // to an earlier item.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_item(lge_op_t'(s_tuser), s_tdata[5:0], s_tdata[11:6], s_tdata[12]);
            if (m_tvalid && m_tready)
                sb.check_result('{read_value: m_tdata[0], changed_cells: m_tdata[13:1],
                                  out_of_range: m_tuser});
        end
    end

    // Ends the run if neither side moves an item for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no item moved in %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offers one item, idling first at the phase's rate, and returns at the
    // falling edge after it was taken. tdata holds row, column, cell value.
    task automatic send_item(input lge_op_t op, input logic [5:0] row,
                             input logic [5:0] column, input logic value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {3'b000, value, column, row};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Stops offering and waits until every owed result has come back, so the
    // engine is idle before the registers change.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        sb.apply_config(idx, value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic resize_grid(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] columns);
        drain_results();
        write_register(CFG_ROWS, rows);
        write_register(CFG_COLS, columns);
        settings_used++;
    endtask

    // Random items, mostly writes and reads inside the grid so that generations
    // have live patterns to work on, with a share of stray accesses and no-ops.
    task automatic run_random(input int count, input int idle_pct, input int stall_pct);
        int      pick;
        lge_op_t op;
        logic [5:0] row;
        logic [5:0] column;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 45) op = OP_WRITE;
            else if (pick < 72) op = OP_READ;
            else if (pick < 94) op = OP_STEP;
            else op = OP_NONE;
            if (sb.rows > 0 && $urandom_range(99) < 85) row = 6'($urandom_range(sb.rows - 1));
            else row = 6'($urandom_range(63));
            if (sb.columns > 0 && $urandom_range(99) < 85)
                column = 6'($urandom_range(sb.columns - 1));
            else column = 6'($urandom_range(63));
            send_item(op, row, column, $urandom_range(99) < 60);
        end
    endtask

    initial begin
        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_WRITE;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_ROWS;
        cfg_data = '0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Full 64 by 64 grid after reset: the corners and edges, an L of three
        // cells that gives a birth, and a lone corner cell that dies.
        send_item(OP_WRITE, 6'd0, 6'd0, 1'b1);
        send_item(OP_WRITE, 6'd0, 6'd1, 1'b1);
        send_item(OP_WRITE, 6'd1, 6'd0, 1'b1);
        send_item(OP_WRITE, 6'd63, 6'd63, 1'b1);
        send_item(OP_WRITE, 6'd63, 6'd62, 1'b0);
        send_item(OP_READ, 6'd0, 6'd0, 1'b0);
        send_item(OP_READ, 6'd63, 6'd63, 1'b1);
        send_item(OP_READ, 6'd62, 6'd62, 1'b0);
        send_item(OP_NONE, 6'd63, 6'd63, 1'b1);
        send_item(OP_STEP, 6'd0, 6'd0, 1'b0);
        send_item(OP_READ, 6'd1, 6'd1, 1'b0);
        send_item(OP_READ, 6'd63, 6'd63, 1'b0);

        // Five rows; a column count above the maximum must saturate to 64.
        resize_grid(7'd5, 7'd127);
        send_item(OP_WRITE, 6'd4, 6'd63, 1'b1);
        send_item(OP_WRITE, 6'd5, 6'd0, 1'b1);
        send_item(OP_READ, 6'd5, 6'd0, 1'b0);
        send_item(OP_READ, 6'd63, 6'd63, 1'b0);
        send_item(OP_READ, 6'd4, 6'd63, 1'b0);
        // A write to an unused register index must leave the world intact.
        drain_results();
        write_register(CFG_UNUSED, 7'd127);
        send_item(OP_READ, 6'd4, 6'd63, 1'b0);
        send_item(OP_STEP, 6'd0, 6'd0, 1'b0);

        // An empty grid: every access is outside and a generation changes nothing.
        drain_results();
        write_register(CFG_COLS, 7'd0);
        settings_used++;
        send_item(OP_WRITE, 6'd0, 6'd0, 1'b1);
        send_item(OP_READ, 6'd0, 6'd0, 1'b0);
        send_item(OP_STEP, 6'd0, 6'd0, 1'b0);
        send_item(OP_NONE, 6'd0, 6'd0, 1'b0);

        // Random phases across sizes and idling patterns.
        resize_grid(7'd8, 7'd8);
        run_random(20, 0, 0);
        resize_grid(7'd6, 7'd11);
        run_random(20, 69, 0);
        resize_grid(7'd1, 7'd1);
        run_random(20, 0, 69);
        resize_grid(7'd16, 7'd3);
        run_random(20, 21, 21);
        resize_grid(7'd64, 7'd64);
        run_random(15, 21, 21);

        // Back-pressure: the receiver refuses results for a long stretch while
        // the sender keeps offering, so the engine fills and stalls its input.
        resize_grid(7'd4, 7'd4);
        hold_off_req = 1'b1;
        run_random(20, 0, 0);

        drain_results();
        repeat (20) @(negedge aclk);
        while (sb.pending.size() != 0) begin
            sb.report_mismatch("expected result item never arrived");
            void'(sb.pending.pop_front());
        end
        $display("Covered %0d items and %0d results over %0d grid settings,",
                 sb.items_seen, sb.results_seen, settings_used);
        $display("from empty and 1x1 grids to the full 64x64, with idling and back-pressure.");
        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
